@@ rtl/capped_edit_distance_macros.svh @@
// ----------------------------------------------------------------------------
// capped_edit_distance_macros.svh
// Assertion macros shared by the capped edit distance block.
// ----------------------------------------------------------------------------
`ifndef CAPPED_EDIT_DISTANCE_MACROS_SVH
`define CAPPED_EDIT_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
// check cons in the same cycle as ante
`define CED_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capped_edit_distance: assertion failed");
// check cons in the cycle after ante
`define CED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capped_edit_distance: assertion failed");
`else
`define CED_ASSERT_SAME(label, ante, cons)
`define CED_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/ced_pkg.sv @@
// ----------------------------------------------------------------------------
// ced_pkg
// Types and constants of the capped edit distance block.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int CP_W        = 21;
  localparam int DIST_W      = 9;
  localparam int CFG_W       = 9;
  localparam int MAX_LEN_DEF = 256;

  localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic {
    OP_FIRST  = 1'b0,
    OP_SECOND = 1'b1
  } ced_op_t;

  typedef struct packed {
    ced_op_t          opcode;
    logic [CP_W-1:0]  code_point;
    logic             is_last;
    logic             is_empty;
  } ced_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } ced_out_t;

  // control bits of a token walking the chain
  typedef struct packed {
    logic upd;  // carries a second-sequence element
    logic fin;  // ends the second sequence
  } ced_tok_ctl_t;

endpackage

@@ rtl/ced_cell.sv @@
// ----------------------------------------------------------------------------
// ced_cell
// One column of the score row: holds one first-sequence code point and its
// score, updates it when a token passes and hands the token on.
// ----------------------------------------------------------------------------
module ced_cell
  import ced_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int INDEX   = 1,
  localparam int LW     = $clog2(MAX_LEN + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            init,
  input  logic            load,
  input  logic [CP_W-1:0] load_cp,
  input  logic [LW-1:0]   len,
  input  ced_tok_ctl_t    in_ctl,
  input  logic [LW-1:0]   in_left,
  input  logic [LW-1:0]   in_diag,
  input  logic [CP_W-1:0] in_cp,
  output ced_tok_ctl_t    out_ctl,
  output logic [LW-1:0]   out_left,
  output logic [LW-1:0]   out_diag,
  output logic [CP_W-1:0] out_cp
);

  localparam logic [LW-1:0] IDX = LW'(INDEX);

  logic [CP_W-1:0] code;
  logic [LW-1:0]   row;
  logic            active;
  logic [LW:0]     up1, left1, diag1, m1, vmin;
  logic [LW-1:0]   v;

  assign active = (IDX <= len);

  always_comb begin
    up1   = {1'b0, row} + (LW+1)'(1);
    left1 = {1'b0, in_left} + (LW+1)'(1);
    diag1 = {1'b0, in_diag} + {{LW{1'b0}}, (code != in_cp)};
    m1    = (up1 < left1) ? up1 : left1;
    vmin  = (m1 < diag1) ? m1 : diag1;
    v     = vmin[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code <= load_cp;
    end
    if (init) begin
      row <= IDX;
    end else if (in_ctl.upd && active) begin
      row <= v;
    end
  end

  // pass the token; columns past the first length forward the left score
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_left <= (active && in_ctl.upd) ? v : in_left;
    out_diag <= row;
    out_cp   <= in_cp;
  end

endmodule

@@ rtl/capped_edit_distance.sv @@
// ----------------------------------------------------------------------------
// capped_edit_distance
// Capped unit-cost edit distance between two code-point sequences, computed
// by a systolic row of cells as a skewed wavefront.
// ----------------------------------------------------------------------------
// Usage: load the first sequence one word per cycle (opcode first), then
// stream the second sequence one word per cycle. Each cell holds one
// first-sequence element and its score; a second-sequence element enters the
// head of the chain and moves one cell per clock. The word that ends the
// second sequence starts a drain through all MAX_LEN cells, and in_stall
// stays high from its acceptance until the result word is taken; the result
// word is registered once that word's token leaves the last cell. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "capped_edit_distance_macros.svh"

module capped_edit_distance
  import ced_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ced_in_t          in_data,
  output logic             in_stall,
  output logic             out_valid,
  output ced_out_t         out_data,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);

  // control
  logic [LW-1:0]    first_length, first_length_next;
  logic [LW-1:0]    second_length, second_length_next;
  logic             first_complete, first_complete_next;
  logic             overflow_seen, overflow_seen_next;
  logic             res_empty, res_empty_next;
  logic             busy, busy_next;
  logic             out_valid_next;
  ced_out_t         out_data_next;
  logic [CFG_W-1:0] max_distance;

  ced_tok_ctl_t     head_ctl, head_ctl_next;
  logic [LW-1:0]    head_left, head_left_next;
  logic [LW-1:0]    head_diag, head_diag_next;
  logic [CP_W-1:0]  head_cp;

  logic             in_acc;
  logic             init;
  logic             wr_en;
  logic [LW-1:0]    base_len;
  logic [LW-1:0]    wr_pos;
  logic [LW-1:0]    d_raw;
  logic [CW-1:0]    d_wide, cap_wide, d_cap;

  // chain taps: entry 0 is the head register, entry j the output of cell j
  ced_tok_ctl_t     ctl  [MAX_LEN+1];
  logic [LW-1:0]    left [MAX_LEN+1];
  logic [LW-1:0]    diag [MAX_LEN+1];
  logic [CP_W-1:0]  cp   [MAX_LEN+1];

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !busy;
  assign base_len  = first_complete ? '0 : first_length;
  assign wr_pos    = base_len + LW'(1);

  assign ctl[0]  = head_ctl;
  assign left[0] = head_left;
  assign diag[0] = head_diag;
  assign cp[0]   = head_cp;

  always_comb begin
    d_raw    = overflow_seen ? MAX_LEN_L : (res_empty ? first_length : left[MAX_LEN]);
    d_wide   = CW'(d_raw);
    cap_wide = CW'(max_distance);
    d_cap    = (d_wide < cap_wide) ? d_wide : cap_wide;
  end

  always_comb begin
    first_length_next   = first_length;
    second_length_next  = second_length;
    first_complete_next = first_complete;
    overflow_seen_next  = overflow_seen;
    res_empty_next      = res_empty;
    busy_next           = busy;
    out_valid_next      = out_valid;
    out_data_next       = out_data;
    head_ctl_next       = '0;
    head_left_next      = second_length + LW'(1);
    head_diag_next      = second_length;
    init                = 1'b0;
    wr_en               = 1'b0;

    if (in_acc) begin
      case (in_data.opcode)
        OP_FIRST: begin
          if (first_complete) begin
            first_length_next   = '0;
            second_length_next  = '0;
            first_complete_next = 1'b0;
            overflow_seen_next  = 1'b0;
          end
          if (in_data.is_empty) begin
            first_length_next   = '0;
            first_complete_next = 1'b1;
          end else begin
            if (base_len < MAX_LEN_L) begin
              wr_en             = 1'b1;
              first_length_next = wr_pos;
            end else begin
              overflow_seen_next = 1'b1;
            end
            if (in_data.is_last) begin
              first_complete_next = 1'b1;
            end
          end
        end
        OP_SECOND: begin
          if (first_complete) begin
            if (in_data.is_empty) begin
              head_ctl_next.fin = 1'b1;
              res_empty_next    = 1'b1;
              busy_next         = 1'b1;
            end else begin
              if (second_length == '0) begin
                init = 1'b1;
              end
              if (second_length < MAX_LEN_L) begin
                second_length_next = second_length + LW'(1);
                head_ctl_next.upd  = 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
              if (in_data.is_last) begin
                head_ctl_next.fin = 1'b1;
                res_empty_next    = 1'b0;
                busy_next         = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // drain done: present the word and drop the pair
    if (ctl[MAX_LEN].fin) begin
      out_valid_next         = 1'b1;
      out_data_next.distance = DIST_W'(d_cap);
      out_data_next.too_long = overflow_seen;
      first_length_next      = '0;
      second_length_next     = '0;
      first_complete_next    = 1'b0;
      overflow_seen_next     = 1'b0;
    end

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
      busy_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length   <= '0;
      second_length  <= '0;
      first_complete <= 1'b0;
      overflow_seen  <= 1'b0;
      res_empty      <= 1'b0;
      busy           <= 1'b0;
      out_valid      <= 1'b0;
      head_ctl       <= '0;
      max_distance   <= CAP_RESET;
    end else begin
      first_length   <= first_length_next;
      second_length  <= second_length_next;
      first_complete <= first_complete_next;
      overflow_seen  <= overflow_seen_next;
      res_empty      <= res_empty_next;
      busy           <= busy_next;
      out_valid      <= out_valid_next;
      head_ctl       <= head_ctl_next;
      if (cfg_valid) begin
        max_distance <= cfg_data;
      end
    end
    out_data  <= out_data_next;
    head_left <= head_left_next;
    head_diag <= head_diag_next;
    head_cp   <= in_data.code_point;
  end

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    ced_cell #(
      .MAX_LEN (MAX_LEN),
      .INDEX   (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .init     (init),
      .load     (wr_en && (wr_pos == LW'(j))),
      .load_cp  (in_data.code_point),
      .len      (first_length),
      .in_ctl   (ctl[j-1]),
      .in_left  (left[j-1]),
      .in_diag  (diag[j-1]),
      .in_cp    (cp[j-1]),
      .out_ctl  (ctl[j]),
      .out_left (left[j]),
      .out_diag (diag[j]),
      .out_cp   (cp[j])
    );
  end

  // a finishing token only ever reaches the tail of a pending pair
  `CED_ASSERT_SAME(a_fin_pending, ctl[MAX_LEN].fin, busy && !out_valid)
  // a result word always belongs to a pair that holds the input
  `CED_ASSERT_SAME(a_out_busy, out_valid, busy)
  // once a pair ends, no new word enters until its result is taken
  `CED_ASSERT_NEXT(a_fin_stall, in_acc && head_ctl_next.fin, in_stall && ctl[0].fin)

endmodule

@@ tb/capped_edit_distance_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capped_edit_distance_tb
// Self-checking bench for the capped edit distance block. A directed table
// covers the corner cases first: second sequence before first, empty
// markers, abandoned pairs and exact matches. Random pairs over small
// alphabets follow, plus one full-length overflowing pair, under several
// caps and three idle mixes. Every result word is checked against the
// table's typed expectation or a local row-update scorer.
// ----------------------------------------------------------------------------
module capped_edit_distance_tb;
  import ced_pkg::*;

  localparam int SEQ_MAX    = MAX_LEN_DEF;
  localparam int QUIET_MAX  = 4000;
  localparam int SETTLE_CYC = SEQ_MAX + 20;
  localparam int PHASE_WORDS = 30;

  typedef struct packed {
    ced_in_t  word;
    logic     fixed;  // expected result typed into the table
    ced_out_t want;
  } stim_t;

  typedef struct packed {
    ced_op_t           op;
    logic [CP_W-1:0]   cp;
    logic              last;
    logic              empty;
    logic              fixed;
    logic [DIST_W-1:0] exp_dist;
    logic              tl;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    // second sequence with no first loaded: dropped
    '{OP_SECOND, 21'd9,       1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd0,       1'b0, 1'b1, 1'b0, 9'd0, 1'b0},
    // extremes of the code point, then an empty second
    '{OP_FIRST,  21'd0,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_FIRST,  21'h10FFFF,  1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_FIRST,  21'd5,       1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'h10FFFF,  1'b1, 1'b1, 1'b1, 9'd3, 1'b0},
    // empty first against two elements
    '{OP_FIRST,  21'h10FFFF,  1'b1, 1'b1, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd7,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd8,       1'b1, 1'b0, 1'b1, 9'd2, 1'b0},
    // both empty
    '{OP_FIRST,  21'd0,       1'b0, 1'b1, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd0,       1'b0, 1'b1, 1'b1, 9'd0, 1'b0},
    // swapped pair: two substitutions
    '{OP_FIRST,  21'd1,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_FIRST,  21'd2,       1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd2,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd1,       1'b1, 1'b0, 1'b1, 9'd2, 1'b0},
    // new first sequence abandons the pair in flight
    '{OP_FIRST,  21'd1,       1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd9,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_FIRST,  21'd3,       1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd3,       1'b1, 1'b0, 1'b1, 9'd0, 1'b0},
    // empty marker ends a second that already has an element
    '{OP_FIRST,  21'd4,       1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd4,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_SECOND, 21'd4,       1'b1, 1'b1, 1'b1, 9'd1, 1'b0},
    // empty marker ends a first that already has an element
    '{OP_FIRST,  21'd6,       1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
    '{OP_FIRST,  21'd6,       1'b1, 1'b1, 1'b0, 9'd0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  ced_in_t          in_data = '0;
  logic             in_stall;
  logic             out_valid;
  ced_out_t         out_data;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  capped_edit_distance #(.MAX_LEN(SEQ_MAX)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // scorer state
  logic [CP_W-1:0]  first_cps [SEQ_MAX];
  int unsigned      row_sc [SEQ_MAX+1];
  int unsigned      len_a;
  int unsigned      len_b;
  bit               a_done;
  bit               ovf;
  logic [CFG_W-1:0] cap_reg = CAP_RESET;

  stim_t    stim_q [$];
  ced_out_t dist_pending_q [$];
  stim_t    cur;
  ced_out_t pred_res;
  ced_out_t want_res;
  bit       pred_hit;
  bit       progress;
  int       quiet_cycles = 0;
  int       sender_pct = 7;
  int       recv_pct = 70;
  int       mismatches = 0;
  int       words_in = 0;
  int       results_seen = 0;
  int       counted = 0;
  logic [CP_W-1:0] alpha [4];

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void clear_pair();
    len_a = 0;
    len_b = 0;
    a_done = 1'b0;
    ovf = 1'b0;
  endfunction

  function automatic int unsigned min_u(int unsigned x, int unsigned y);
    return (x < y) ? x : y;
  endfunction

  // one row of unit-cost scores against the whole first sequence
  function automatic void advance_row(logic [CP_W-1:0] c);
    int unsigned diag;
    int unsigned up;
    int unsigned j;
    diag = row_sc[0];
    row_sc[0] = len_b;
    for (j = 1; j <= len_a; j++) begin
      up = row_sc[j];
      row_sc[j] = min_u(min_u(up + 1, row_sc[j-1] + 1),
                        diag + ((first_cps[j-1] == c) ? 0 : 1));
      diag = up;
    end
  endfunction

  function automatic bit score_word(input ced_in_t w, output ced_out_t r);
    int unsigned d;
    int unsigned j;
    r = '0;
    if (w.opcode == OP_FIRST) begin
      if (a_done) clear_pair();
      if (w.is_empty) begin
        len_a = 0;
        a_done = 1'b1;
        return 1'b0;
      end
      if (len_a < SEQ_MAX) begin
        first_cps[len_a] = w.code_point;
        len_a++;
      end else begin
        ovf = 1'b1;
      end
      if (w.is_last) a_done = 1'b1;
      return 1'b0;
    end
    if (!a_done) return 1'b0;
    if (w.is_empty) begin
      d = len_a;
    end else begin
      if (len_b == 0) begin
        for (j = 0; j <= len_a; j++) row_sc[j] = j;
      end
      if (len_b < SEQ_MAX) begin
        len_b++;
        advance_row(w.code_point);
      end else begin
        ovf = 1'b1;
      end
      if (!w.is_last) return 1'b0;
      d = row_sc[len_a];
    end
    if (ovf) d = SEQ_MAX;
    d = min_u(d, cap_reg);
    r.distance = d[DIST_W-1:0];
    r.too_long = ovf;
    clear_pair();
    return 1'b1;
  endfunction

  // drive the input side, predict, check results, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
      clear_pair();
    end else begin
      progress = 1'b0;
      if (in_valid && !in_stall) begin
        progress = 1'b1;
        words_in++;
        pred_hit = score_word(cur.word, pred_res);
        if (cur.fixed) dist_pending_q = {dist_pending_q, cur.want};
        else if (pred_hit) dist_pending_q = {dist_pending_q, pred_res};
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        results_seen++;
        if (dist_pending_q.size() == 0) begin
          flag_mismatch("result word with nothing expected", out_data.distance, -1);
        end else begin
          want_res = dist_pending_q.pop_front();
          if (out_data.distance !== want_res.distance)
            flag_mismatch("distance", out_data.distance, want_res.distance);
          if (out_data.too_long !== want_res.too_long)
            flag_mismatch("too_long", out_data.too_long, want_res.too_long);
        end
      end
      if (cfg_valid && cfg_ready) progress = 1'b1;
      // advance to the next word only when the slot is free
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= sender_pct) begin
          cur = stim_q.pop_front();
          in_valid <= 1'b1;
          in_data <= cur.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_pct);
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_MAX);
        $display("capped_edit_distance regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [CP_W-1:0] rand_cp();
    return CP_W'($urandom_range(0, 21'h10FFFF));
  endfunction

  task automatic push_word(ced_in_t w);
    stim_t s;
    s = {w, 1'b0, {(DIST_W+1){1'b0}}};
    stim_q = {stim_q, s};
  endtask

  // a sequence of len elements, or an empty marker when len is zero
  task automatic push_seq(ced_op_t op, int len, bit wide, bit ends);
    ced_in_t w;
    int i;
    w.opcode = op;
    if (len == 0) begin
      w.code_point = rand_cp();
      w.is_last = 1'($urandom_range(0, 1));
      w.is_empty = 1'b1;
      push_word(w);
      counted++;
      return;
    end
    for (i = 0; i < len; i++) begin
      w.code_point = (wide || $urandom_range(0, 9) == 0) ? rand_cp()
                                                          : alpha[$urandom_range(0, 3)];
      w.is_last = ends && (i == len - 1);
      w.is_empty = 1'b0;
      push_word(w);
      counted++;
    end
  endtask

  task automatic push_pair(int la, int lb, bit wide);
    int k;
    for (k = 0; k < 4; k++) alpha[k] = rand_cp();
    push_seq(OP_FIRST, la, wide, 1'b1);
    push_seq(OP_SECOND, lb, wide, 1'b1);
  endtask

  task automatic write_cap(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  // hold until every word is taken and every result is back, then drain
  task automatic settle();
    while (stim_q.size() != 0 || in_valid) @(negedge clk);
    while (dist_pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  initial begin
    int ph;
    int r;
    int i;
    int n;
    ced_in_t w;
    stim_t s;
    logic [CFG_W-1:0] caps [6];

    caps = '{9'd0, 9'd511, 9'd2, 9'd256, 9'd1, 9'd0};
    caps[5] = CFG_W'($urandom_range(0, 511));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table, run under the reset cap
    for (i = 0; i < DIR_N; i++) begin
      w.opcode = DIRECTED[i].op;
      w.code_point = DIRECTED[i].cp;
      w.is_last = DIRECTED[i].last;
      w.is_empty = DIRECTED[i].empty;
      s = {w, DIRECTED[i].fixed, DIRECTED[i].exp_dist, DIRECTED[i].tl};
      stim_q = {stim_q, s};
    end
    // close with a clean pair so the scorer and block end idle
    push_pair(2, 3, 1'b0);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          sender_pct = 7;
          recv_pct = 70;
        end
        1: begin
          sender_pct = 70;
          recv_pct = 7;
        end
        default: begin
          sender_pct = 0;
          recv_pct = 0;
        end
      endcase
      write_cap(caps[ph]);
      counted = 0;
      // one full-length first sequence that overflows
      if (ph == 3) push_pair(SEQ_MAX + 1, 3, 1'b1);
      counted = 0;
      while (counted < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          push_pair($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 9) == 0);
        end else if (r < 90) begin
          // noise: any opcode and flag mix
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) begin
            w.opcode = ced_op_t'($urandom_range(0, 1));
            w.code_point = rand_cp();
            w.is_last = 1'($urandom_range(0, 1));
            w.is_empty = ($urandom_range(0, 3) == 0);
            push_word(w);
          end
        end else begin
          // broken pair: second left open, dropped by the next first
          for (i = 0; i < 4; i++) alpha[i] = rand_cp();
          push_seq(OP_FIRST, $urandom_range(1, 8), 1'b0, 1'b1);
          push_seq(OP_SECOND, $urandom_range(1, 6), 1'b0, 1'b0);
        end
      end
      push_pair($urandom_range(1, 6), $urandom_range(1, 6), 1'b0);
      settle();
    end

    if (dist_pending_q.size() != 0)
      flag_mismatch("results never delivered", 0, dist_pending_q.size());
    $display("summary: %0d input words, %0d result words checked, %0d mismatches",
             words_in, results_seen, mismatches);
    $display("summary: caps 0 to 511 incl. reset value, one full-length overflow pair");
    if (mismatches == 0) begin
      $display("capped_edit_distance regression: pass");
    end else begin
      $display("capped_edit_distance regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ced_pkg.sv
rtl/ced_cell.sv
rtl/capped_edit_distance.sv
tb/capped_edit_distance_tb.sv
